[rtl/core/mwo_pkg.sv]
// shared types, constants and coefficient tables of the multi-waveform oscillator
`timescale 1ns / 1ps

package mwo_pkg;

  // item field widths
  localparam int FREQ_W    = 19;
  localparam int TIME_W    = 48;
  localparam int IN_DATA_W = 72;
  localparam int SAMPLE_W  = 16;

  // phase product: only the low 36 bits (fraction) of frequency * time matter
  localparam int PROD_FRAC = 36;
  localparam int TP_HALF   = 18;
  localparam int PHASE_W   = 32;

  // parameter defaults
  localparam int HARMONICS_DEF  = 99;
  localparam int PHASE_BITS_DEF = 16;

  // harmonic counter, wide enough for up to 255 harmonics
  localparam int N_W = 8;

  // shared multiplier
  localparam int MUL_W = 32;

  // reciprocal divider: 20-bit dividend, 4 quotient bits a step
  localparam int DIV_W     = 20;
  localparam int DIV_BPS   = 4;
  localparam int DIV_STEPS = DIV_W / DIV_BPS;
  localparam int DIV_REM_W = 9;
  localparam int QUOT_W    = 17;
  localparam int DIV_CNT_W = 3;
  localparam logic [DIV_W-1:0] DIV_BASE = 20'h2_0000;

  // sine polynomial, Q30 Taylor coefficients of sin(pi/2 * x)
  localparam logic [30:0] SIN_C1 = 31'd1686629713;
  localparam logic [30:0] SIN_C3 = 31'd693598668;
  localparam logic [30:0] SIN_C5 = 31'd85569306;
  localparam logic [30:0] SIN_C7 = 31'd5026995;
  localparam logic [30:0] SIN_C9 = 31'd172272;
  localparam logic [30:0] ONE_Q30 = 31'h4000_0000;

  // saw scaling by 2/pi in Q24
  localparam logic [23:0] TWO_OVER_PI_Q24 = 24'd10680707;
  localparam int ACC_W = 36;
  localparam int MAG_W = 18;

  localparam logic [SAMPLE_W-1:0] Q15_MAX = 16'h7FFF;
  localparam logic [SAMPLE_W-1:0] Q15_MIN = 16'h8000;

  // configuration port
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;
  localparam logic REG_WAVEFORM = 1'b0;
  localparam int WAVE_W = 3;

  typedef enum logic [WAVE_W-1:0] {
    WAVE_SINE    = 3'd0,
    WAVE_SQUARE  = 3'd1,
    WAVE_TRI     = 3'd2,
    WAVE_ADD_SAW = 3'd3,
    WAVE_RAMP    = 3'd4
  } wave_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_PH0,
    S_PH1,
    S_DISP,
    S_SQ,
    S_HORN,
    S_RX,
    S_SOUT,
    S_MAC,
    S_ABS,
    S_SC0,
    S_SC1,
    S_SC2,
    S_DONE
  } state_e;

  // status from datapath to sequencer
  typedef struct packed {
    logic              in_valid;
    logic              out_free;
    logic [WAVE_W-1:0] wave;
    logic              last_harm;
    logic              div_done;
  } st_t;

  // control from sequencer to datapath
  typedef struct packed {
    state_e     state;
    logic [1:0] horn_idx;
    logic       take;
    logic       emit;
  } ctl_t;

  // coefficient subtracted from in each horner step, highest order first
  function automatic logic [30:0] horner_coef(input logic [1:0] k);
    logic [30:0] c;
    case (k)
      2'd0:    c = SIN_C7;
      2'd1:    c = SIN_C5;
      2'd2:    c = SIN_C3;
      default: c = SIN_C1;
    endcase
    return c;
  endfunction

endpackage

[rtl/core/multi_waveform_oscillator.sv]
// Multi-waveform oscillator: sine, square, triangle, additive saw and ramp samples.
// Triangle, ramp and silent modes come straight from the phase; sine and square run
// one sine pass, the additive saw one per harmonic up to HARMONICS. An item is taken
// only in idle, after the last result is registered. The single shared multiplier does
// one product a cycle, seven per harmonic (square, four horner steps, by x, accumulate).
// Reset (async, active low) idles the sequencer, empties the output register, selects sine.
`timescale 1ns / 1ps

module multi_waveform_oscillator
  import mwo_pkg::*;
#(
  parameter int HARMONICS  = HARMONICS_DEF,
  parameter int PHASE_BITS = PHASE_BITS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // input items
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [IN_DATA_W-1:0] s_axis_tdata,   // [18:0] frequency, [66:19] time_point
  // result items
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [SAMPLE_W-1:0]  m_axis_tdata,   // [15:0] sample
  // configuration
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [PADDR_W-1:0]   paddr,
  input  logic [PDATA_W-1:0]   pwdata,
  output logic [PDATA_W-1:0]   prdata,
  output logic                 pready
);

  st_t  st;
  ctl_t ctl;

  logic [WAVE_W-1:0]   wave_q;
  logic                out_valid_q;
  logic [SAMPLE_W-1:0] out_data_q;

  logic [FREQ_W-1:0]    f_q;
  logic [PROD_FRAC-1:0] tp_q;
  logic [40:0]          w_q;
  logic [PHASE_W-1:0]   u_q, hp_q;
  logic [30:0]          x_q, x2_q, t_q;
  logic [14:0]          m_q;
  logic                 neg_q;
  logic [ACC_W-1:0]     acc_q;
  logic [N_W-1:0]       n_q;
  logic                 ysgn_q;
  logic [MAG_W-1:0]     mag_q;
  logic [SAMPLE_W-1:0]  res_q;

  logic [MUL_W-1:0]   mul_a, mul_b;
  logic [2*MUL_W-1:0] mul_p;
  logic               div_done;
  logic [QUOT_W-1:0]  quot;

  logic [30:0]          x_sel;
  logic [PROD_FRAC-1:0] ph_sum;
  logic [32:0]          rnd;
  logic [17:0]          m_raw;
  logic [14:0]          m_sat;
  logic [16:0]          tri_a;
  logic [SAMPLE_W-1:0]  direct;
  logic [57:0]          scaled;

  // configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wave_q <= WAVE_W'(WAVE_SINE);
    end else if (psel && penable && pwrite && (paddr[2] == REG_WAVEFORM)) begin
      wave_q <= pwdata[WAVE_W-1:0];
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_WAVEFORM) ? PDATA_W'(wave_q) : '0;

  // sequencer
  assign st.in_valid  = s_axis_tvalid;
  assign st.out_free  = !out_valid_q || m_axis_tready;
  assign st.wave      = wave_q;
  assign st.last_harm = (n_q == N_W'(HARMONICS));
  assign st.div_done  = div_done;

  mwo_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .st_i   (st),
    .ctl_o  (ctl)
  );

  assign s_axis_tready = (ctl.state == S_IDLE);

  // reciprocal of the harmonic number, worked out while the sine runs
  mwo_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (ctl.state == S_SQ),
    .n_i     (n_q),
    .done_o  (div_done),
    .quot_o  (quot)
  );

  // quarter-wave fold of the harmonic phase
  assign x_sel = hp_q[30] ? (ONE_Q30 - {1'b0, hp_q[29:0]}) : {1'b0, hp_q[29:0]};

  // operand select for the shared multiplier
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (ctl.state)
      S_PH0: begin
        mul_a = MUL_W'(f_q);
        mul_b = MUL_W'(tp_q[TP_HALF-1:0]);
      end
      S_PH1: begin
        mul_a = MUL_W'(f_q);
        mul_b = MUL_W'(tp_q[PROD_FRAC-1:TP_HALF]);
      end
      S_SQ: begin
        mul_a = MUL_W'(x_sel);
        mul_b = MUL_W'(x_sel);
      end
      S_HORN: begin
        mul_a = MUL_W'(x2_q);
        mul_b = (ctl.horn_idx == 2'd0) ? MUL_W'(SIN_C9) : MUL_W'(t_q);
      end
      S_RX: begin
        mul_a = MUL_W'(t_q);
        mul_b = MUL_W'(x_q);
      end
      S_MAC: begin
        mul_a = MUL_W'(m_q);
        mul_b = MUL_W'(quot);
      end
      S_SC0: begin
        mul_a = MUL_W'(acc_q[16:0]);
        mul_b = MUL_W'(TWO_OVER_PI_Q24);
      end
      S_SC1: begin
        mul_a = MUL_W'(acc_q[33:17]);
        mul_b = MUL_W'(TWO_OVER_PI_Q24);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  mwo_mul u_mul (
    .a_i (mul_a),
    .b_i (mul_b),
    .p_o (mul_p)
  );

  // phase fraction from the two partial products
  assign ph_sum = w_q[PROD_FRAC-1:0] + {mul_p[TP_HALF-1:0], {TP_HALF{1'b0}}};

  // sine magnitude: round to q15 and clip
  assign rnd   = {1'b0, mul_p[61:30]} + 33'h0_4000;
  assign m_raw = rnd[32:15];
  assign m_sat = (m_raw > 18'd32767) ? 15'h7FFF : m_raw[14:0];

  // waveforms computed straight from the phase
  assign tri_a = u_q[31:15];
  always_comb begin
    direct = '0;
    case (wave_e'(wave_q))
      WAVE_TRI: begin
        if (u_q[31:30] == 2'b00) begin
          direct = SAMPLE_W'(tri_a);
        end else if (u_q[31:30] != 2'b11) begin
          direct = (tri_a == 17'h0_8000) ? Q15_MAX : (16'h0000 - tri_a[15:0]);
        end else begin
          direct = tri_a[15:0];
        end
      end
      WAVE_RAMP: direct = {~u_q[31], u_q[30:16]};
      default:   direct = '0;
    endcase
  end

  // scaled saw magnitude plus rounding half
  assign scaled = {mul_p[40:0], 17'b0} + 58'(w_q) + (58'd1 << 39);

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (ctl.take) begin
      f_q  <= s_axis_tdata[FREQ_W-1:0];
      tp_q <= s_axis_tdata[FREQ_W +: PROD_FRAC];
    end
    case (ctl.state)
      S_PH0: w_q <= mul_p[40:0];
      S_PH1: u_q <= {ph_sum[PROD_FRAC-1 -: PHASE_BITS], {(PHASE_W-PHASE_BITS){1'b0}}};
      S_DISP: begin
        hp_q  <= u_q;
        n_q   <= N_W'(1);
        acc_q <= '0;
        res_q <= direct;
      end
      S_SQ: begin
        x_q   <= x_sel;
        x2_q  <= mul_p[60:30];
        neg_q <= hp_q[31];
      end
      S_HORN: t_q <= 31'(32'(horner_coef(ctl.horn_idx)) - mul_p[61:30]);
      S_RX:   m_q <= m_sat;
      S_SOUT: begin
        if (wave_e'(wave_q) == WAVE_SQUARE) begin
          res_q <= (!neg_q && (m_q != '0)) ? Q15_MAX : Q15_MIN;
        end else begin
          res_q <= neg_q ? (16'h0000 - {1'b0, m_q}) : {1'b0, m_q};
        end
      end
      S_MAC: begin
        if (div_done) begin
          acc_q <= neg_q ? (acc_q - ACC_W'(mul_p[31:0])) : (acc_q + ACC_W'(mul_p[31:0]));
          n_q   <= n_q + 1'b1;
          hp_q  <= hp_q + u_q;
        end
      end
      S_ABS: begin
        ysgn_q <= acc_q[ACC_W-1];
        acc_q  <= acc_q[ACC_W-1] ? (ACC_W'(0) - acc_q) : acc_q;
      end
      S_SC0: w_q   <= mul_p[40:0];
      S_SC1: mag_q <= scaled[57:40];
      S_SC2: begin
        if (ysgn_q) begin
          res_q <= (mag_q > 18'd32768) ? Q15_MIN : (16'h0000 - mag_q[15:0]);
        end else begin
          res_q <= (mag_q > 18'd32767) ? Q15_MAX : mag_q[15:0];
        end
      end
      default: begin
      end
    endcase
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctl.emit) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl.emit) begin
      out_data_q <= res_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

`ifndef SYNTHESIS
  a_take_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> ctl.state == S_PH0)
    else $error("accepted item did not start the phase product");

  a_harm_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl.state == S_MAC |-> (n_q != '0) && (n_q <= N_W'(HARMONICS)))
    else $error("harmonic counter out of range");

  a_div_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl.state == S_MAC |-> div_done)
    else $error("reciprocal not ready at accumulate");

  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl.emit |-> !out_valid_q || m_axis_tready)
    else $error("result overwrote an untaken item");

  a_wave_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(psel && penable && pwrite) |=> $stable(wave_q))
    else $error("waveform register changed without a write");
`endif

endmodule

[rtl/core/mwo_mul.sv]
// shared 32 x 32 unsigned multiplier of the oscillator datapath
`timescale 1ns / 1ps

module mwo_mul
  import mwo_pkg::*;
(
  input  logic [MUL_W-1:0]   a_i,
  input  logic [MUL_W-1:0]   b_i,
  output logic [2*MUL_W-1:0] p_o
);

  // full-width product, registered by the caller
  assign p_o = 64'(a_i) * 64'(b_i);

endmodule

[rtl/core/mwo_div.sv]
// iterative reciprocal divider: round(65536 / n) as (2^17 + n) / (2n)
`timescale 1ns / 1ps

module mwo_div
  import mwo_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [N_W-1:0]    n_i,
  output logic              done_o,
  output logic [QUOT_W-1:0] quot_o
);

  logic [DIV_CNT_W-1:0] cnt_q;
  logic [DIV_W-1:0]     num_q, num_d;
  logic [DIV_REM_W-1:0] rem_q, rem_d;
  logic [DIV_REM_W-1:0] dv_q;

  // four restoring steps, dividend bits shift out as quotient bits shift in
  always_comb begin
    logic [DIV_REM_W-1:0] rem;
    logic [DIV_W-1:0]     num;
    logic [DIV_REM_W:0]   r;
    rem = rem_q;
    num = num_q;
    r   = '0;
    for (int i = 0; i < DIV_BPS; i++) begin
      r   = {rem, num[DIV_W-1]};
      num = {num[DIV_W-2:0], 1'b0};
      if (r >= {1'b0, dv_q}) begin
        r      = r - {1'b0, dv_q};
        num[0] = 1'b1;
      end
      rem = r[DIV_REM_W-1:0];
    end
    rem_d = rem;
    num_d = num;
  end

  // step counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (start_i) begin
      cnt_q <= DIV_CNT_W'(DIV_STEPS);
    end else if (cnt_q != '0) begin
      cnt_q <= cnt_q - 1'b1;
    end
  end

  // operand and partial remainder
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= DIV_BASE + DIV_W'(n_i);
      rem_q <= '0;
      dv_q  <= {n_i, 1'b0};
    end else if (cnt_q != '0) begin
      num_q <= num_d;
      rem_q <= rem_d;
    end
  end

  assign done_o = (cnt_q == '0);
  assign quot_o = num_q[QUOT_W-1:0];

endmodule

[rtl/core/mwo_ctrl.sv]
// sequencer that steps the shared multiplier through each item
`timescale 1ns / 1ps

module mwo_ctrl
  import mwo_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  st_t  st_i,
  output ctl_t ctl_o
);

  state_e     state_q, state_d;
  logic [1:0] k_q, k_d;

  // state and horner step registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      k_q     <= '0;
    end else begin
      state_q <= state_d;
      k_q     <= k_d;
    end
  end

  // next state and strobes
  always_comb begin
    state_d       = state_q;
    k_d           = k_q;
    ctl_o.state   = state_q;
    ctl_o.horn_idx = k_q;
    ctl_o.take    = 1'b0;
    ctl_o.emit    = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (st_i.in_valid) begin
          ctl_o.take = 1'b1;
          state_d    = S_PH0;
        end
      end
      S_PH0: state_d = S_PH1;
      S_PH1: state_d = S_DISP;
      S_DISP: begin
        case (wave_e'(st_i.wave))
          WAVE_SINE, WAVE_SQUARE, WAVE_ADD_SAW: state_d = S_SQ;
          default:                              state_d = S_DONE;
        endcase
      end
      S_SQ: begin
        k_d     = '0;
        state_d = S_HORN;
      end
      S_HORN: begin
        if (k_q == 2'd3) begin
          state_d = S_RX;
        end else begin
          k_d = k_q + 1'b1;
        end
      end
      S_RX: begin
        if (wave_e'(st_i.wave) == WAVE_ADD_SAW) begin
          state_d = S_MAC;
        end else begin
          state_d = S_SOUT;
        end
      end
      S_SOUT: state_d = S_DONE;
      S_MAC: begin
        if (st_i.div_done) begin
          state_d = st_i.last_harm ? S_ABS : S_SQ;
        end
      end
      S_ABS: state_d = S_SC0;
      S_SC0: state_d = S_SC1;
      S_SC1: state_d = S_SC2;
      S_SC2: state_d = S_DONE;
      S_DONE: begin
        if (st_i.out_free) begin
          ctl_o.emit = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

endmodule
